>>> hw/rtl/bts_pkg.sv
// Shared types and constants of the bucket tag sort engine.
// Holds the controller/datapath command and status structs; no dependencies.
package bts_pkg;

    localparam int VALUE_W   = 16;  // width of the value ports
    localparam int TAG_W     = 3;   // width of the bucket tag
    localparam int TAG_SCALE = 5;   // tag = floor(value * TAG_SCALE / largest)
    localparam int DIV_STEPS = 3;   // quotient bits resolved by the tag divider

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // an input item is transferred this cycle
        logic load_last;  // the transferred item closes the set
        logic rd_i;       // read the entry at the outer sort index
        logic ld_v;       // latch the key, start the inner walk
        logic cmp_step;   // one inner step of the insertion sort
        logic out_init;   // rewind the index for the output pass
        logic out_rd;     // read the entry to be emitted
        logic div_start;  // start the tag division on the read entry
        logic emit;       // present one result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic i_done;     // outer index has reached the item count
        logic shift;      // inner walk moves the compared entry up
        logic div_done;   // tag divider has finished
        logic out_last;   // current output is the final one of the run
    } t_status;

endpackage

>>> hw/rtl/bucket_tag_sort_engine.sv
// Top level of the bucket tag sort engine.
// Joins bts_ctrl and bts_datapath; uses bts_pkg for the shared command types.
//
// Usage. Values are loaded one per transfer: an item is taken at a rising
// clock edge where start is high and busy is low. Up to MAX_ITEMS values are
// kept; further values are dropped until the set closes. The running
// maximum is tracked while loading. An item with i_is_last high closes the
// set and raises busy on the next cycle.
// The block then insertion-sorts the stored values in place in its value
// memory, one compare per cycle during each inner walk, and afterwards walks
// the sorted set. For each entry a restoring divider forms the tag
// floor(value*5/max), or 0 when the maximum is 0, and the result appears on
// o_sorted_value, o_bucket and o_last_out for exactly one cycle with
// o_strobe high. o_last_out marks the final result of the run. The receiver
// cannot stall: each strobe is a completed transfer.
// For n stored values the sort moves at most n(n-1)/2 elements, and for each
// result the output pass does a memory read, a divider start, the divider's
// three steps and its done flag.
// busy falls with the final strobe, with count and maximum cleared for the next set.
// Reset (synchronous, active low) empties the set and returns to loading;
// the memory needs no clearing pass since only written entries are read.
module bucket_tag_sort_engine #(
    parameter int MAX_ITEMS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bts_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_is_last,
    output logic                          o_strobe,
    output logic [bts_pkg::VALUE_W-1:0]   o_sorted_value,
    output logic [bts_pkg::TAG_W-1:0]     o_bucket,
    output logic                          o_last_out
);
    import bts_pkg::*;

    // Only the low VALUE_BITS bits of a value count, and no more than the
    // port carries, so the memory is no wider than that.
    localparam int STORE_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    t_cmd    cmd;
    t_status status;

    bts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    bts_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .STORE_BITS (STORE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_status       (status),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_bucket       (o_bucket),
        .o_last_out     (o_last_out)
    );

endmodule

>>> hw/rtl/bts_tag_div.sv
// Iterative restoring divider for the bucket tag, one quotient bit per cycle.
// Depends on bts_pkg for the tag width and step count.
module bts_tag_div #(
    parameter int DEN_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DEN_BITS+2:0]          i_num,
    input  logic [DEN_BITS-1:0]          i_den,
    output logic [bts_pkg::TAG_W-1:0]    o_quot,
    output logic                         o_done
);
    import bts_pkg::*;

    localparam int NUM_W = DEN_BITS + TAG_W;

    logic [NUM_W-1:0]    r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [1:0]          r_step;
    logic [TAG_W-1:0]    r_quot;
    logic                r_run;
    logic                r_done;
    logic [NUM_W-1:0]    trial;
    logic                take;

    assign trial = NUM_W'(r_den) << r_step;
    // A zero divisor only occurs with a zero numerator; the tag is then 0.
    assign take  = (r_den != '0) && (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_step == 2'd0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
            r_step <= 2'(DIV_STEPS - 1);
        end else if (r_run) begin
            if (take) begin
                r_rem          <= r_rem - trial;
                r_quot[r_step] <= 1'b1;
            end
            if (r_step != 2'd0) begin
                r_step <= r_step - 2'd1;
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

>>> hw/rtl/bts_datapath.sv
// Datapath of the bucket tag sort engine: value memory, counters, running
// maximum, insertion sort walk, tag divider and result registers. Uses bts_pkg.
module bts_datapath #(
    parameter int MAX_ITEMS  = 16,
    parameter int STORE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bts_pkg::t_cmd                 i_cmd,
    input  logic [bts_pkg::VALUE_W-1:0]   i_value,
    output bts_pkg::t_status              o_status,
    output logic                          o_strobe,
    output logic [bts_pkg::VALUE_W-1:0]   o_sorted_value,
    output logic [bts_pkg::TAG_W-1:0]     o_bucket,
    output logic                          o_last_out
);
    import bts_pkg::*;

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int NUM_W = STORE_BITS + TAG_W;

    logic [STORE_BITS-1:0] r_mem [MAX_ITEMS];
    logic [STORE_BITS-1:0] r_rdata;
    logic [STORE_BITS-1:0] r_v;
    logic [STORE_BITS-1:0] r_max;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_i;
    logic [AW-1:0]         r_j;

    logic                  r_strobe;
    logic [VALUE_W-1:0]    r_sorted_value;
    logic [TAG_W-1:0]      r_bucket;
    logic                  r_last_out;

    logic [STORE_BITS-1:0] in_val;
    logic                  full;
    logic                  shift;
    logic                  out_last;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [STORE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [NUM_W-1:0]      div_num;
    logic [TAG_W-1:0]      div_quot;
    logic                  div_done;

    assign in_val   = i_value[STORE_BITS-1:0];
    assign full     = (r_count == CW'(MAX_ITEMS));
    assign shift    = (r_j != '0) && (r_rdata > r_v);
    assign out_last = ((r_i + CW'(1)) == r_count);

    // One write port and one read port on the value memory.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_j;
        wr_data = r_v;
        rd_en   = 1'b0;
        rd_addr = r_i[AW-1:0];
        if (i_cmd.load && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = in_val;
        end
        if (i_cmd.rd_i || i_cmd.out_rd) begin
            rd_en = 1'b1;
        end
        if (i_cmd.ld_v) begin
            rd_en   = 1'b1;
            rd_addr = r_i[AW-1:0] - AW'(1);
        end
        if (i_cmd.cmp_step) begin
            wr_en = 1'b1;
            if (shift) begin
                wr_data = r_rdata;
                rd_en   = 1'b1;
                rd_addr = r_j - AW'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_max    <= '0;
            r_i      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.load && !full) begin
                r_count <= r_count + CW'(1);
                if (in_val > r_max) begin
                    r_max <= in_val;
                end
            end
            if (i_cmd.emit && out_last) begin
                r_count <= '0;
                r_max   <= '0;
            end
            if (i_cmd.load_last) begin
                r_i <= CW'(1);
            end else if (i_cmd.out_init) begin
                r_i <= '0;
            end else if ((i_cmd.cmp_step && !shift) || i_cmd.emit) begin
                r_i <= r_i + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_v) begin
            r_v <= r_rdata;
            r_j <= r_i[AW-1:0];
        end else if (i_cmd.cmp_step && shift) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.emit) begin
            r_sorted_value <= VALUE_W'(r_rdata);
            r_bucket       <= div_quot;
            r_last_out     <= out_last;
        end
    end

    assign div_num = NUM_W'(r_rdata) * NUM_W'(TAG_SCALE);

    bts_tag_div #(
        .DEN_BITS (STORE_BITS)
    ) u_tag_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_max),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    assign o_status.i_done   = (r_i >= r_count);
    assign o_status.shift    = shift;
    assign o_status.div_done = div_done;
    assign o_status.out_last = out_last;

    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_sorted_value;
    assign o_bucket       = r_bucket;
    assign o_last_out     = r_last_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("item count exceeds the store depth");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && out_last |=> (r_count == '0) && (r_max == '0))
        else $error("count or maximum not cleared after the final result");

    a_max_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && !full |=> r_max >= $past(in_val))
        else $error("running maximum below a stored value");

    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> div_done)
        else $error("result emitted before the tag division finished");

endmodule

>>> hw/rtl/bts_ctrl.sv
// Controller of the bucket tag sort engine: sequences load, sort and output.
// Issues bts_pkg::t_cmd to the datapath and reads bts_pkg::t_status back.
module bts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_is_last,
    input  bts_pkg::t_status i_status,
    output bts_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import bts_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_CHK,
        ST_SORT_LD,
        ST_SORT_CMP,
        ST_OUT_RD,
        ST_OUT_DIV,
        ST_OUT_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load      = i_start;
                o_cmd.load_last = i_start && i_is_last;
                if (i_start && i_is_last) begin
                    n_state = ST_SORT_CHK;
                end
            end
            ST_SORT_CHK: begin
                if (i_status.i_done) begin
                    o_cmd.out_init = 1'b1;
                    n_state        = ST_OUT_RD;
                end else begin
                    o_cmd.rd_i = 1'b1;
                    n_state    = ST_SORT_LD;
                end
            end
            ST_SORT_LD: begin
                o_cmd.ld_v = 1'b1;
                n_state    = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                o_cmd.cmp_step = 1'b1;
                if (!i_status.shift) begin
                    n_state = ST_SORT_CHK;
                end
            end
            ST_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = ST_OUT_DIV;
            end
            ST_OUT_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                o_cmd.emit = i_status.div_done;
                if (i_status.div_done) begin
                    n_state = i_status.out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_LOAD);
        end
    end

    assign o_busy = r_busy;

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != ST_LOAD))
        else $error("busy flag disagrees with the controller state");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_cmd.load)
        else $error("item taken while busy");

    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_last |=> r_busy && (r_state == ST_SORT_CHK))
        else $error("final item did not start the sort");

endmodule
